@@ hw/rtl/per_cell_threshold_persistence_check_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the per-cell threshold persistence check
// Same-cycle and next-cycle implication checks, clocked and reset-gated.
// ----------------------------------------------------------------------------
`ifndef PER_CELL_THRESHOLD_PERSISTENCE_CHECK_ASSERT_SVH
`define PER_CELL_THRESHOLD_PERSISTENCE_CHECK_ASSERT_SVH

// check cons in the same cycle as ante
`define PCTP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// check cons in the cycle after ante
`define PCTP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/pctp_pkg.sv @@
// ----------------------------------------------------------------------------
// pctp_pkg
// Field widths, request kinds and register indexes of the cell fault checker.
// ----------------------------------------------------------------------------
package pctp_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int HOLD_W      = 16;
    localparam int TIME_W      = 32;
    localparam int TRIP_W      = 5;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_IDX_W   = 8;
    localparam int CFG_DATA_W  = 16;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND_MODE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD        = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS       = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAGNITUDE_MODE   = 8'd3;

    typedef logic [TIME_W-1:0] time_val_t;

endpackage

@@ hw/rtl/per_cell_threshold_persistence_check.sv @@
// ----------------------------------------------------------------------------
// per_cell_threshold_persistence_check: cell fault qualifier with hold timers
// Accepts one beat per cycle unless a held result beat stalls it; the sweep result
// beat passes the input register (start-time RAM read alongside), then the output register.
// Synchronous active-low reset clears time, timers, sweep state and valid flags.
// ----------------------------------------------------------------------------
`include "per_cell_threshold_persistence_check_assert.svh"

module per_cell_threshold_persistence_check #(
    parameter int MAX_CELLS = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [pctp_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [pctp_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [pctp_pkg::SAMPLE_W-1:0]        s_tdata,   // [15:0] sample_value
    input  logic [0:0]                           s_tuser,   // [0] req_type
    input  logic                                 s_tlast,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [pctp_pkg::OUT_TDATA_W-1:0]     m_tdata    // [4:0] tripped_cell
);

    localparam int PW = $clog2(MAX_CELLS + 1);
    localparam int CW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;

    // configuration
    logic                                upper_reg;
    logic signed [pctp_pkg::SAMPLE_W-1:0] thr_reg;
    logic [pctp_pkg::HOLD_W-1:0]         hold_reg;
    logic                                mag_reg;

    // front end
    pctp_pkg::time_val_t                 time_reg;
    logic [PW-1:0]                       pos_reg;
    logic                                s_accept;
    logic                                s_sample;

    // evaluation stage
    logic                                p1_valid_reg;
    logic                                p1_valid_next;
    logic                                p1_sample_reg;
    logic                                p1_last_reg;
    logic [pctp_pkg::SAMPLE_W-1:0]       p1_value_reg;
    logic [CW-1:0]                       p1_cell_reg;
    logic                                p1_inrange_reg;
    pctp_pkg::time_val_t                 p1_time_reg;
    logic                                p1_emit;
    logic                                p1_eval;
    logic                                p1_advance;

    // timer state
    logic [MAX_CELLS-1:0]                run_reg;
    logic [MAX_CELLS-1:0]                run_next;
    logic [MAX_CELLS-1:0]                done_reg;
    logic [MAX_CELLS-1:0]                done_next;
    logic [PW-1:0]                       trip_reg;
    logic [PW-1:0]                       trip_next;

    // start-time RAM
    logic [CW-1:0]                       rd_addr;
    pctp_pkg::time_val_t                 ram_rdata;
    logic                                start_we;
    logic                                fwd_reg;
    pctp_pkg::time_val_t                 fwd_data_reg;

    // compare and timer logic
    logic signed [pctp_pkg::SAMPLE_W:0]  val_ext;
    logic signed [pctp_pkg::SAMPLE_W:0]  val_cmp;
    logic signed [pctp_pkg::SAMPLE_W:0]  thr_ext;
    logic                                cond;
    logic                                run_old;
    logic                                done_old;
    logic                                started;
    logic                                run_mid;
    logic                                done_mid;
    pctp_pkg::time_val_t                 start_prev;
    pctp_pkg::time_val_t                 start_eff;
    pctp_pkg::time_val_t                 elapsed;
    logic                                expire;
    logic                                run_new;
    logic                                done_new;
    logic                                hit;
    logic [PW-1:0]                       cell_num;

    // output register
    logic                                m_valid_reg;
    logic                                m_valid_next;
    logic [pctp_pkg::TRIP_W-1:0]         m_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upper_reg <= 1'b1;
            thr_reg   <= '0;
            hold_reg  <= '0;
            mag_reg   <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                pctp_pkg::REG_UPPER_BOUND_MODE: upper_reg <= cfg_data[0];
                pctp_pkg::REG_THRESHOLD:        thr_reg   <= cfg_data;
                pctp_pkg::REG_HOLD_TICKS:       hold_reg  <= cfg_data;
                pctp_pkg::REG_MAGNITUDE_MODE:   mag_reg   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign s_accept = s_tvalid && s_tready;
    assign s_sample = (s_tuser[0] == pctp_pkg::REQ_SAMPLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_reg <= '0;
            pos_reg  <= '0;
        end else if (s_accept) begin
            if (!s_sample) begin
                time_reg <= time_reg + 1'b1;
            end else if (s_tlast) begin
                pos_reg <= '0;
            end else if (pos_reg < PW'(MAX_CELLS)) begin
                pos_reg <= pos_reg + 1'b1;
            end
        end
    end

    assign p1_emit    = p1_sample_reg && p1_last_reg;
    assign p1_advance = p1_valid_reg && (!p1_emit || !m_valid_reg || m_tready);
    assign s_tready   = !p1_valid_reg || p1_advance;

    always_comb begin
        p1_valid_next = p1_valid_reg;
        if (s_accept) begin
            p1_valid_next = 1'b1;
        end else if (p1_advance) begin
            p1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            p1_sample_reg  <= s_sample;
            p1_last_reg    <= s_tlast;
            p1_value_reg   <= s_tdata;
            p1_cell_reg    <= pos_reg[CW-1:0];
            p1_inrange_reg <= (pos_reg < PW'(MAX_CELLS));
            p1_time_reg    <= time_reg;
        end
    end

    // hold the read address on the staged cell while stalled
    assign rd_addr  = s_accept ? pos_reg[CW-1:0] : p1_cell_reg;
    assign start_we = p1_advance && p1_eval && started;

    pctp_ram #(
        .WIDTH (pctp_pkg::TIME_W),
        .DEPTH (MAX_CELLS)
    ) u_start_ram (
        .aclk    (aclk),
        .wr_en   (start_we),
        .wr_addr (p1_cell_reg),
        .wr_data (p1_time_reg),
        .rd_addr (rd_addr),
        .rd_data (ram_rdata)
    );

    // bypass a start time written in the same cycle it was read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fwd_reg <= 1'b0;
        end else begin
            fwd_reg <= start_we && (p1_cell_reg == rd_addr);
        end
        fwd_data_reg <= p1_time_reg;
    end

    assign start_prev = fwd_reg ? fwd_data_reg : ram_rdata;

    assign p1_eval  = p1_sample_reg && p1_inrange_reg && (trip_reg == '0);
    assign val_ext  = {p1_value_reg[pctp_pkg::SAMPLE_W-1], p1_value_reg};
    assign val_cmp  = (mag_reg && p1_value_reg[pctp_pkg::SAMPLE_W-1]) ? -val_ext : val_ext;
    assign thr_ext  = {thr_reg[pctp_pkg::SAMPLE_W-1], thr_reg};
    assign cond     = upper_reg ? (val_cmp > thr_ext) : (val_cmp < thr_ext);

    assign run_old  = p1_inrange_reg ? run_reg[p1_cell_reg] : 1'b0;
    assign done_old = p1_inrange_reg ? done_reg[p1_cell_reg] : 1'b0;
    assign started  = cond && !run_old && !done_old;
    assign run_mid  = cond && (run_old || !done_old);
    assign done_mid = cond && done_old;

    assign start_eff = started ? p1_time_reg : start_prev;
    assign elapsed   = p1_time_reg - start_eff;
    assign expire    = run_mid && (elapsed >= pctp_pkg::TIME_W'(hold_reg));
    assign run_new   = run_mid && !expire;
    assign done_new  = done_mid || expire;
    assign hit       = p1_eval && done_new;
    assign cell_num  = PW'(p1_cell_reg) + 1'b1;

    always_comb begin
        run_next  = run_reg;
        done_next = done_reg;
        trip_next = trip_reg;
        if (p1_advance && p1_eval) begin
            run_next[p1_cell_reg]  = run_new;
            done_next[p1_cell_reg] = done_new;
        end
        if (p1_advance && p1_sample_reg) begin
            if (p1_last_reg) begin
                trip_next = '0;
            end else if (hit) begin
                trip_next = cell_num;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= '0;
            done_reg <= '0;
            trip_reg <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            trip_reg <= trip_next;
        end
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (p1_advance && p1_emit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (p1_advance && p1_emit) begin
            m_data_reg <= pctp_pkg::TRIP_W'(hit ? cell_num : trip_reg);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = pctp_pkg::OUT_TDATA_W'(m_data_reg);

    `PCTP_ASSERT_NOW(a_result_from_sweep_end, aclk, aresetn, $rose(m_valid_reg), $past(p1_advance && p1_emit), "result beat without a sweep end")
    `PCTP_ASSERT_NOW(a_timer_exclusive, aclk, aresetn, p1_valid_reg && p1_eval, !(run_new && done_new), "timer both running and done")
    `PCTP_ASSERT_NOW(a_trip_bound, aclk, aresetn, 1'b1, trip_reg <= PW'(MAX_CELLS), "tripped index beyond cell count")
    `PCTP_ASSERT_NOW(a_pos_bound, aclk, aresetn, 1'b1, pos_reg <= PW'(MAX_CELLS), "sweep position beyond cell count")
    `PCTP_ASSERT_NEXT(a_sweep_clear, aclk, aresetn, p1_advance && p1_emit, trip_reg == '0, "tripped index kept past sweep end")

endmodule

@@ hw/rtl/pctp_ram.sv @@
// ----------------------------------------------------------------------------
// pctp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pctp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                      aclk,
    input  logic                                      wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                          wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                          rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
